// ----- rtl/core/leaky_relu_neuron_trainer_defines.svh -----
// Assertion macros shared by the leaky ReLU neuron trainer RTL.
// The including module must have signals named clk and rst_n.
`ifndef LEAKY_RELU_NEURON_TRAINER_DEFINES_SVH
`define LEAKY_RELU_NEURON_TRAINER_DEFINES_SVH

`ifndef SYNTHESIS
`define LRNT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define LRNT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define LRNT_ASSERT_IMP(lbl, ante, cons)
`define LRNT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/lrnt_pkg.sv -----
// Package for the leaky ReLU neuron trainer: widths, codes, payload types
// and saturation helpers. It depends on nothing else.
`timescale 1ns / 1ps

package lrnt_pkg;

    localparam int MAX_INPUTS  = 16;
    localparam int DATA_BITS   = 16;
    localparam int IDX_W       = $clog2(MAX_INPUTS);
    localparam int CNT_W       = $clog2(MAX_INPUTS + 1);
    localparam int ACC_W       = 40;
    localparam int Z_W         = ACC_W + 1;
    localparam int HI_W        = 42;
    localparam int NEG_W       = HI_W + 1;
    localparam int SAT_W       = 64;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 17;
    localparam int MUL_W       = MUL_A_W + MUL_B_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] REG_INPUTS_IN_USE = 2'd0;
    localparam logic [1:0] REG_STEP_SIZE     = 2'd1;
    localparam logic [1:0] REG_LEAK_FACTOR   = 2'd2;

    localparam logic [4:0]  INPUTS_IN_USE_RESET = 5'd16;
    localparam logic [15:0] STEP_SIZE_RESET     = 16'd655;
    localparam logic [15:0] LEAK_FACTOR_RESET   = 16'd655;

    localparam logic RES_ACTIVATION = 1'b0;
    localparam logic RES_DELTA      = 1'b1;

    typedef enum logic [2:0] {
        KIND_LOAD_W   = 3'd0,
        KIND_LOAD_B   = 3'd1,
        KIND_FEED     = 3'd2,
        KIND_BACKPROP = 3'd3,
        KIND_TRAIN    = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         index;
        logic signed [15:0] value;
        logic               last;
    } req_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [3:0]         result_index;
        logic signed [15:0] result_value;
        logic               result_last;
    } rsp_item_t;

    typedef struct packed {
        kind_t              op;
        logic [3:0]         index;
        logic signed [15:0] value;
        logic               last;
        logic               in_use;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      rate;
        logic [15:0]      leak;
    } cfg_t;

    function automatic logic signed [DATA_BITS-1:0] sat_data(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0]     hi;
        logic signed [SAT_W-1:0]     lo;
        logic signed [DATA_BITS-1:0] r;
        hi = (SAT_W'(1) <<< (DATA_BITS - 1)) - SAT_W'(1);
        lo = -hi - SAT_W'(1);
        if (v > hi)
        begin
            r = hi[DATA_BITS-1:0];
        end
        else if (v < lo)
        begin
            r = lo[DATA_BITS-1:0];
        end
        else
        begin
            r = v[DATA_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1])
        begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/lrnt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
`timescale 1ns / 1ps

module lrnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lrnt_front.sv -----
// Front end: takes requests, drops unknown kinds and marks whether the
// index is in use. Depends on lrnt_pkg.
`timescale 1ns / 1ps

module lrnt_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  lrnt_pkg::req_item_t     req_data,
    input  logic [lrnt_pkg::CNT_W-1:0] count,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output lrnt_pkg::cmd_t          cmd
);

    import lrnt_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    cmd_t hold_next;
    logic accept;
    logic known;

    assign req_ready = !hold_valid_reg || cmd_ready;
    assign accept    = req_valid && req_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_comb
    begin
        unique case (req_data.kind)
            KIND_LOAD_W, KIND_LOAD_B, KIND_FEED, KIND_BACKPROP, KIND_TRAIN: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !cmd_ready;
        hold_next       = hold_reg;
        if (accept && known)
        begin
            hold_valid_next  = 1'b1;
            hold_next.op     = kind_t'(req_data.kind);
            hold_next.index  = req_data.index;
            hold_next.value  = req_data.value;
            hold_next.last   = req_data.last;
            hold_next.in_use = {1'b0, req_data.index} < count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ----- rtl/core/lrnt_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on lrnt_pkg.
`timescale 1ns / 1ps

module lrnt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  lrnt_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output lrnt_pkg::cmd_t pop_cmd
);

    import lrnt_pkg::*;

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg;
    logic [QUEUE_PTR_W:0]   fill_next;
    logic                   push;
    logic                   pop;

    assign push_ready = fill_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QUEUE_PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/lrnt_back.sv -----
// Back end: a sequencer around one shared multiplier and the weight RAM that
// carries out queued commands and drives the result register.
// Depends on lrnt_pkg, lrnt_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "leaky_relu_neuron_trainer_defines.svh"

module lrnt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  lrnt_pkg::cmd_t     q_cmd,
    input  lrnt_pkg::cfg_t     cfg,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lrnt_pkg::rsp_item_t rsp_data
);

    import lrnt_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_FEED_MUL = 17'h00002,
        S_FEED_ACC = 17'h00004,
        S_ACT_Z    = 17'h00008,
        S_ACT_HI   = 17'h00010,
        S_ACT_LO   = 17'h00020,
        S_ACT_NEG  = 17'h00040,
        S_ACT_EMIT = 17'h00080,
        S_BP_DELTA = 17'h00100,
        S_BP_RD    = 17'h00200,
        S_BP_MUL   = 17'h00400,
        S_BP_EMIT  = 17'h00800,
        S_TR_MUL1  = 17'h01000,
        S_TR_MUL2  = 17'h02000,
        S_TR_UPD   = 17'h04000,
        S_TR_BIAS  = 17'h08000,
        S_TR_BUPD  = 17'h10000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    cmd_t                        cmd_reg;
    cmd_t                        cmd_next;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [Z_W-1:0]       z_reg;
    logic signed [Z_W-1:0]       z_next;
    logic signed [HI_W-1:0]      hi_reg;
    logic signed [HI_W-1:0]      hi_next;
    logic signed [MUL_W-1:0]     mul_reg;
    logic signed [MUL_W-1:0]     mul_next;
    logic signed [DATA_BITS-1:0] bias_reg;
    logic signed [DATA_BITS-1:0] bias_next;
    logic signed [DATA_BITS-1:0] last_act_reg;
    logic signed [DATA_BITS-1:0] last_act_next;
    logic signed [DATA_BITS-1:0] delta_reg;
    logic signed [DATA_BITS-1:0] delta_next;
    logic [IDX_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            cnt_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    rsp_item_t                   out_data_reg;
    rsp_item_t                   out_data_next;

    logic                        mul_en;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [DATA_BITS-1:0]        ram_wdata;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_raddr;
    logic [DATA_BITS-1:0]        ram_rdata;
    logic signed [DATA_BITS-1:0] weight_rd;
    logic signed [NEG_W-1:0]     neg_sum;
    logic                        out_slot_free;
    logic                        bp_last;

    lrnt_ram #(
        .WIDTH(DATA_BITS),
        .DEPTH(MAX_INPUTS)
    ) u_weight_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign weight_rd     = signed'(ram_rdata);
    assign q_ready       = state_reg == S_IDLE;
    assign rsp_valid     = out_valid_reg;
    assign rsp_data      = out_data_reg;
    assign out_slot_free = !out_valid_reg || rsp_ready;
    assign bp_last       = (CNT_W'(cnt_reg) + CNT_W'(1)) == cfg.count;
    assign neg_sum       = NEG_W'(hi_reg) + NEG_W'(signed'({1'b0, mul_reg[31:16]}));
    assign mul_next      = mul_en ? MUL_W'(mul_a) * MUL_W'(mul_b) : mul_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        acc_next       = acc_reg;
        z_next         = z_reg;
        hi_next        = hi_reg;
        bias_next      = bias_reg;
        last_act_next  = last_act_reg;
        delta_next     = delta_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;
        ram_waddr      = cmd_reg.index;
        ram_wdata      = cmd_reg.value;
        ram_re         = 1'b0;
        ram_raddr      = cmd_reg.index;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    unique case (q_cmd.op)
                        KIND_LOAD_W:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = q_cmd.index;
                            ram_wdata = q_cmd.value;
                        end
                        KIND_LOAD_B:
                        begin
                            bias_next = q_cmd.value;
                        end
                        KIND_FEED:
                        begin
                            if (q_cmd.in_use)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = q_cmd.index;
                                state_next = S_FEED_MUL;
                            end
                            else if (q_cmd.last)
                            begin
                                state_next = S_ACT_Z;
                            end
                        end
                        KIND_BACKPROP:
                        begin
                            if (last_act_reg > 0)
                            begin
                                delta_next = q_cmd.value;
                                state_next = S_BP_RD;
                            end
                            else
                            begin
                                mul_en     = 1'b1;
                                mul_a      = MUL_A_W'(q_cmd.value);
                                mul_b      = signed'({1'b0, cfg.leak});
                                state_next = S_BP_DELTA;
                            end
                        end
                        KIND_TRAIN:
                        begin
                            if (q_cmd.in_use)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = q_cmd.index;
                                state_next = S_TR_MUL1;
                            end
                            else if (q_cmd.last)
                            begin
                                state_next = S_TR_BIAS;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FEED_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(cmd_reg.value);
                mul_b      = MUL_B_W'(weight_rd);
                state_next = S_FEED_ACC;
            end
            S_FEED_ACC:
            begin
                acc_next   = sat_acc((ACC_W + 1)'(acc_reg)
                                     + (ACC_W + 1)'(signed'(mul_reg[31:0])));
                state_next = cmd_reg.last ? S_ACT_Z : S_IDLE;
            end
            S_ACT_Z:
            begin
                z_next     = (Z_W'(bias_reg) <<< 12) + Z_W'(acc_reg);
                acc_next   = '0;
                state_next = S_ACT_HI;
            end
            S_ACT_HI:
            begin
                if (z_reg[Z_W-1])
                begin
                    mul_en     = 1'b1;
                    mul_a      = MUL_A_W'(signed'(z_reg[Z_W-1:16]));
                    mul_b      = signed'({1'b0, cfg.leak});
                    state_next = S_ACT_LO;
                end
                else
                begin
                    last_act_next = sat_data(SAT_W'(z_reg >>> 12));
                    state_next    = S_ACT_EMIT;
                end
            end
            S_ACT_LO:
            begin
                hi_next    = signed'(mul_reg[HI_W-1:0]);
                mul_en     = 1'b1;
                mul_a      = signed'({17'b0, z_reg[15:0]});
                mul_b      = signed'({1'b0, cfg.leak});
                state_next = S_ACT_NEG;
            end
            S_ACT_NEG:
            begin
                last_act_next = sat_data(SAT_W'(neg_sum >>> 12));
                state_next    = S_ACT_EMIT;
            end
            S_ACT_EMIT:
            begin
                if (out_slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.result_kind  = RES_ACTIVATION;
                    out_data_next.result_index = '0;
                    out_data_next.result_value = last_act_reg;
                    out_data_next.result_last  = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            S_BP_DELTA:
            begin
                delta_next = sat_data(SAT_W'(mul_reg >>> 16));
                state_next = S_BP_RD;
            end
            S_BP_RD:
            begin
                cnt_next = '0;
                if (cfg.count == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = S_BP_MUL;
                end
            end
            S_BP_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(weight_rd);
                mul_b      = MUL_B_W'(delta_reg);
                state_next = S_BP_EMIT;
            end
            S_BP_EMIT:
            begin
                if (out_slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.result_kind  = RES_DELTA;
                    out_data_next.result_index = cnt_reg;
                    out_data_next.result_value = sat_data(SAT_W'(mul_reg >>> 12));
                    out_data_next.result_last  = bp_last;
                    if (bp_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        ram_re     = 1'b1;
                        ram_raddr  = cnt_reg + IDX_W'(1);
                        state_next = S_BP_MUL;
                    end
                end
            end
            S_TR_MUL1:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(delta_reg);
                mul_b      = MUL_B_W'(cmd_reg.value);
                state_next = S_TR_MUL2;
            end
            S_TR_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'(mul_reg[MUL_A_W-1:0]);
                mul_b      = signed'({1'b0, cfg.rate});
                state_next = S_TR_UPD;
            end
            S_TR_UPD:
            begin
                ram_we     = 1'b1;
                ram_wdata  = sat_data(SAT_W'(weight_rd) - SAT_W'(mul_reg >>> 28));
                state_next = cmd_reg.last ? S_TR_BIAS : S_IDLE;
            end
            S_TR_BIAS:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(delta_reg);
                mul_b      = signed'({1'b0, cfg.rate});
                state_next = S_TR_BUPD;
            end
            S_TR_BUPD:
            begin
                bias_next  = sat_data(SAT_W'(bias_reg) - SAT_W'(mul_reg >>> 16));
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            bias_reg      <= '0;
            last_act_reg  <= '0;
            delta_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            bias_reg      <= bias_next;
            last_act_reg  <= last_act_next;
            delta_reg     <= delta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        z_reg        <= z_next;
        hi_reg       <= hi_next;
        mul_reg      <= mul_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    `LRNT_ASSERT_NEXT(a_acc_cleared, state_reg == S_ACT_Z, acc_reg == '0)
    `LRNT_ASSERT_IMP(a_neg_path_sign, state_reg == S_ACT_LO || state_reg == S_ACT_NEG, z_reg[Z_W-1])
    `LRNT_ASSERT_IMP(a_bp_cnt_range, state_reg == S_BP_MUL || state_reg == S_BP_EMIT, (CNT_W'(cnt_reg) < cfg.count))
    `LRNT_ASSERT_NEXT(a_bp_done, state_reg == S_BP_EMIT && out_slot_free && bp_last, state_reg == S_IDLE && out_valid_reg && out_data_reg.result_last)

endmodule

// ----- rtl/core/leaky_relu_neuron_trainer.sv -----
// Leaky ReLU neuron trainer top level: configuration registers and the
// front end, command queue and back end. Depends on lrnt_pkg and submodules.
//
// Requests arrive on req_valid/req_ready with a req_data payload; results
// leave on rsp_valid/rsp_ready with rsp_data. Both sides use valid/ready
// and a transfer happens when both are high at a rising edge.
// The APB port holds inputs_in_use (0x0), the step size (0x4) and
// leak_factor (0x8); pready is always high and reads return the values.
// A request passes through the front register and then the queue.
// Loads finish in the back end's idle state; a feed element reads,
// multiplies and accumulates; an activation multiplies by the leak twice
// when negative; a backprop scales the delta unless the last activation
// was positive, then multiplies and emits per weight in use; a train
// element multiplies twice and writes, then updates the bias on the last one.
// Reset clears the queue, the sequencer, the bias, accumulator, stored
// activation and delta, and restores the register reset values.
// When the receiver stalls, a result waits in the output register, the
// back end halts at its next result, and the queue and front end fill
// before req_ready falls.
`timescale 1ns / 1ps

module leaky_relu_neuron_trainer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  lrnt_pkg::req_item_t                 req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output lrnt_pkg::rsp_item_t                 rsp_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrnt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lrnt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lrnt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import lrnt_pkg::*;

    logic [4:0]  inputs_reg;
    logic [4:0]  inputs_next;
    logic [15:0] rate_reg;
    logic [15:0] rate_next;
    logic [15:0] leak_reg;
    logic [15:0] leak_next;
    logic        cfg_write;
    logic [1:0]  reg_sel;
    cfg_t        cfg;
    logic        f_valid;
    logic        f_ready;
    cmd_t        f_cmd;
    logic        q_valid;
    logic        q_ready;
    cmd_t        q_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_comb
    begin
        inputs_next = inputs_reg;
        rate_next   = rate_reg;
        leak_next   = leak_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_INPUTS_IN_USE: inputs_next = pwdata[4:0];
                REG_STEP_SIZE:     rate_next   = pwdata[15:0];
                REG_LEAK_FACTOR:   leak_next   = pwdata[15:0];
                default:           inputs_next = inputs_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_INPUTS_IN_USE: prdata = CFG_DATA_W'(inputs_reg);
            REG_STEP_SIZE:     prdata = CFG_DATA_W'(rate_reg);
            REG_LEAK_FACTOR:   prdata = CFG_DATA_W'(leak_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inputs_reg <= INPUTS_IN_USE_RESET;
            rate_reg   <= STEP_SIZE_RESET;
            leak_reg   <= LEAK_FACTOR_RESET;
        end
        else
        begin
            inputs_reg <= inputs_next;
            rate_reg   <= rate_next;
            leak_reg   <= leak_next;
        end
    end

    assign cfg.count = (inputs_reg > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS) : inputs_reg;
    assign cfg.rate  = rate_reg;
    assign cfg.leak  = leak_reg;

    lrnt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .count    (cfg.count),
        .cmd_valid(f_valid),
        .cmd_ready(f_ready),
        .cmd      (f_cmd)
    );

    lrnt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_cmd  (f_cmd),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cmd   (q_cmd)
    );

    lrnt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .cfg      (cfg),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

endmodule

// ----- tb/tb_leaky_relu_neuron_trainer.sv -----
// Self-checking testbench for the leaky ReLU neuron trainer: random and directed requests,
// an in-bench prediction of every result, and APB register writes between phases.
// Depends on lrnt_pkg and the leaky_relu_neuron_trainer RTL.
`timescale 1ns / 1ps

module tb_leaky_relu_neuron_trainer;

    import lrnt_pkg::*;

    localparam int          CLK_PERIOD   = 20;
    localparam int          RUN_LIMIT    = 500000;
    localparam int          IDLE_PAD     = 60;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
    localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
    localparam logic [15:0] Q_MAX        = 16'h7fff;
    localparam logic [15:0] Q_MIN        = 16'h8000;
    localparam longint      ACC_HI       = (longint'(1) <<< 39) - 1;
    localparam longint      ACC_LO       = -(longint'(1) <<< 39);

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    req_item_t       req_data  = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    rsp_item_t       rsp_data;
    logic            psel      = 1'b0;
    logic            penable   = 1'b0;
    logic            pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic            pready;

    req_item_t       request_backlog[$];
    rsp_item_t       due_outputs[$];
    int              mismatches  = 0;
    int              cycle_count = 0;

    logic signed [15:0] weight_mem [MAX_INPUTS];
    logic signed [15:0] bias_q  = '0;
    logic signed [39:0] acc_q   = '0;
    logic signed [15:0] act_q   = '0;
    logic signed [15:0] delta_q = '0;
    logic [4:0]         cfg_count = INPUTS_IN_USE_RESET;
    logic [15:0]        cfg_rate  = STEP_SIZE_RESET;
    logic [15:0]        cfg_leak  = LEAK_FACTOR_RESET;

    int              burst_left = 0;
    int              gap_left   = 0;
    int              rx_count   = 0;
    int              hold_left  = 0;
    logic            hold_done  = 1'b0;
    int              rx_mode    = 0;
    int              rx_mode_left = 0;

    leaky_relu_neuron_trainer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic logic signed [15:0] clamp_q412(input longint v);
        logic signed [15:0] r;
        if (v > 32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic int count_in_use();
        int n;
        n = (cfg_count > MAX_INPUTS) ? MAX_INPUTS : int'(cfg_count);
        return n;
    endfunction

    function automatic void predict_neuron(input req_item_t rq);
        longint    val;
        longint    sum;
        longint    z;
        longint    act;
        longint    step;
        int        n;
        int        i;
        rsp_item_t r;
        val = longint'($signed(rq.value));
        n = count_in_use();
        case (rq.kind)
            KIND_LOAD_W:
            begin
                weight_mem[rq.index] = rq.value;
            end
            KIND_LOAD_B:
            begin
                bias_q = rq.value;
            end
            KIND_FEED:
            begin
                if (int'(rq.index) < n)
                begin
                    sum = longint'(acc_q) + val * longint'(weight_mem[rq.index]);
                    if (sum > ACC_HI)
                    begin
                        sum = ACC_HI;
                    end
                    else if (sum < ACC_LO)
                    begin
                        sum = ACC_LO;
                    end
                    acc_q = sum[39:0];
                end
                if (rq.last)
                begin
                    z = longint'(bias_q) * 4096 + longint'(acc_q);
                    act = (z < 0) ? ((z * longint'(cfg_leak)) >>> 28) : (z >>> 12);
                    act_q = clamp_q412(act);
                    acc_q = '0;
                    r.result_kind  = RES_ACTIVATION;
                    r.result_index = 4'd0;
                    r.result_value = act_q;
                    r.result_last  = 1'b1;
                    due_outputs.insert(due_outputs.size(), r);
                end
            end
            KIND_BACKPROP:
            begin
                if (act_q > 0)
                begin
                    delta_q = rq.value;
                end
                else
                begin
                    delta_q = clamp_q412((val * longint'(cfg_leak)) >>> 16);
                end
                for (i = 0; i < n; i++)
                begin
                    r.result_kind  = RES_DELTA;
                    r.result_index = 4'(i);
                    r.result_value = clamp_q412((longint'(weight_mem[i]) *
                                                 longint'(delta_q)) >>> 12);
                    r.result_last  = (i == n - 1);
                    due_outputs.insert(due_outputs.size(), r);
                end
            end
            KIND_TRAIN:
            begin
                if (int'(rq.index) < n)
                begin
                    step = (longint'(delta_q) * val * longint'(cfg_rate)) >>> 28;
                    weight_mem[rq.index] = clamp_q412(longint'(weight_mem[rq.index]) - step);
                end
                if (rq.last)
                begin
                    step = (longint'(delta_q) * longint'(cfg_rate)) >>> 16;
                    bias_q = clamp_q412(longint'(bias_q) - step);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string fname, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_req(input logic [2:0] k, input logic [3:0] idx,
                                     input logic [15:0] v, input logic lst);
        req_item_t rq;
        rq.kind  = k;
        rq.index = idx;
        rq.value = v;
        rq.last  = lst;
        request_backlog.insert(request_backlog.size(), rq);
    endfunction

    function automatic logic [15:0] pick_q412();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = 16'd0;
            3, 4, 5: v = 16'($signed($urandom_range(0, 16384)) - 8192);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // A vector of feed or train requests over the positions in use, with the occasional
    // stray position outside the count; the last mark goes on the final request.
    function automatic int queue_vector(input logic [2:0] k);
        int n;
        int len;
        int offs;
        int i;
        int made;
        n = count_in_use();
        made = 0;
        if (n == 0)
        begin
            push_req(k, 4'($urandom_range(0, 15)), pick_q412(), 1'b1);
            return 1;
        end
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
        offs = $urandom_range(0, n - 1);
        for (i = 0; i < len; i++)
        begin
            if (n < MAX_INPUTS && $urandom_range(0, 7) == 0)
            begin
                push_req(k, 4'($urandom_range(n, MAX_INPUTS - 1)), pick_q412(), 1'b0);
                made++;
            end
            push_req(k, 4'((i + offs) % n), pick_q412(), i == len - 1);
            made++;
        end
        return made;
    endfunction

    task automatic run_random(input int items);
        int made;
        made = 0;
        while (made < items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    made += queue_vector(KIND_FEED);
                    push_req(KIND_BACKPROP, 4'($urandom), pick_q412(), 1'($urandom));
                    made += 1 + queue_vector(KIND_TRAIN);
                end
                6:
                begin
                    push_req(KIND_LOAD_W, 4'($urandom), pick_q412(), 1'($urandom));
                    made++;
                end
                7:
                begin
                    push_req(KIND_LOAD_B, 4'($urandom), pick_q412(), 1'($urandom));
                    made++;
                end
                8:
                begin
                    push_req(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                             4'($urandom), 16'($urandom), 1'($urandom));
                    push_req(($urandom_range(0, 1) != 0) ? KIND_FEED : KIND_TRAIN,
                             4'($urandom), pick_q412(), 1'($urandom));
                    made += 2;
                end
                default:
                begin
                    push_req(KIND_BACKPROP, 4'($urandom), pick_q412(), 1'($urandom));
                    made++;
                end
            endcase
        end
    endtask

    task automatic settle();
        while (request_backlog.size() != 0 || req_valid || due_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] reg_idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_INPUTS_IN_USE: cfg_count = data[4:0];
            REG_STEP_SIZE:     cfg_rate  = data[15:0];
            REG_LEAK_FACTOR:   cfg_leak  = data[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic write_all_cfg(input logic [31:0] cnt, input logic [31:0] rate,
                                 input logic [31:0] leak);
        write_cfg(REG_INPUTS_IN_USE, cnt);
        write_cfg(REG_STEP_SIZE, rate);
        write_cfg(REG_LEAK_FACTOR, leak);
    endtask

    // Request source: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (request_backlog.size() != 0)
            begin
                req_data  <= request_backlog.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result sink: stall pattern that changes mode at random intervals, plus one long
    // hold-off while requests are still queued so that the block backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rx_count <= rx_count + 1;
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && rx_count >= 20 && request_backlog.size() > 40)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      <= $urandom_range(0, 3);
                    rx_mode_left <= $urandom_range(8, 60);
                end
                else
                begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                case (rx_mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 7) != 0);
                    default: rsp_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_outputs.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, %s %0d %0d %0d %0d",
                             $time, "actual kind, index, value, last",
                             rsp_data.result_kind, rsp_data.result_index,
                             $signed(rsp_data.result_value), rsp_data.result_last);
                    mismatches++;
                end
                else
                begin
                    check_field("result_kind", due_outputs[0].result_kind,
                                rsp_data.result_kind);
                    check_field("result_index", due_outputs[0].result_index,
                                rsp_data.result_index);
                    check_field("result_value", $signed(due_outputs[0].result_value),
                                $signed(rsp_data.result_value));
                    check_field("result_last", due_outputs[0].result_last,
                                rsp_data.result_last);
                    void'(due_outputs.pop_front());
                end
            end
            if (req_valid && req_ready)
            begin
                predict_neuron(req_data);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < MAX_INPUTS; i++)
        begin
            push_req(KIND_LOAD_W, 4'(i),
                     (i == 0) ? Q_MAX : (i == 1) ? Q_MIN : pick_q412(), 1'b0);
        end
        push_req(KIND_LOAD_B, 4'hf, Q_MIN, 1'b1);
        push_req(KIND_FEED, 4'd0, Q_MAX, 1'b0);
        push_req(KIND_FEED, 4'd1, Q_MIN, 1'b1);
        push_req(KIND_BACKPROP, 4'd0, Q_MIN, 1'b0);
        push_req(KIND_TRAIN, 4'd0, Q_MAX, 1'b0);
        push_req(KIND_TRAIN, 4'd3, Q_MIN, 1'b1);
        push_req(KIND_SPARE_LO, 4'hf, 16'hffff, 1'b1);
        push_req(KIND_SPARE_HI, 4'h0, 16'h0000, 1'b0);
        push_req(KIND_FEED, 4'd15, 16'd0, 1'b1);
        push_req(KIND_BACKPROP, 4'hf, Q_MAX, 1'b1);

        // No weight in use, largest rate, no leak.
        settle();
        write_all_cfg(0, 16'hffff, 0);
        run_random(25);

        // Count beyond the weight store, no learning, largest leak.
        settle();
        write_all_cfg(31, 0, 16'hffff);
        run_random(50);

        settle();
        write_all_cfg(1, 16'hffff, 16'hffff);
        run_random(25);

        // Reset values again, a write to the spare address and a reloaded weight.
        settle();
        write_all_cfg(16, STEP_SIZE_RESET, LEAK_FACTOR_RESET);
        write_cfg(REG_UNUSED, 32'h0000_0003);
        push_req(KIND_LOAD_W, 4'd0, Q_MIN, 1'b0);
        push_req(KIND_LOAD_W, 4'd0, pick_q412(), 1'b0);
        run_random(35);

        repeat (2)
        begin
            settle();
            write_all_cfg($urandom_range(1, 16), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            run_random(40);
        end

        settle();
        if (mismatches == 0 && due_outputs.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lrnt_pkg.sv
rtl/core/lrnt_ram.sv
rtl/core/lrnt_front.sv
rtl/core/lrnt_queue.sv
rtl/core/lrnt_back.sv
rtl/core/leaky_relu_neuron_trainer.sv
tb/tb_leaky_relu_neuron_trainer.sv
